/* hdl/fccw_pkg.sv */
// Shared types and constants of the FAT12 cluster chain walker.
`timescale 1ns / 1ps
package fccw_pkg;

  localparam logic [11:0] END_MARK       = 12'hFF8;
  localparam logic [3:0]  NIBBLE         = 4'hF;
  localparam int          DIR_ENTRY_LOG2 = 5;

  localparam logic [2:0] CFG_RESERVED_SECTORS = 3'd0;
  localparam logic [2:0] CFG_FAT_COPIES       = 3'd1;
  localparam logic [2:0] CFG_SECTORS_PER_FAT  = 3'd2;
  localparam logic [2:0] CFG_SECTOR_BYTES     = 3'd3;
  localparam logic [2:0] CFG_ROOT_ENTRY_COUNT = 3'd4;

  localparam logic [15:0] RST_RESERVED_SECTORS = 16'd1;
  localparam logic [7:0]  RST_FAT_COPIES       = 8'd2;
  localparam logic [15:0] RST_SECTORS_PER_FAT  = 16'd9;
  localparam logic [15:0] RST_SECTOR_BYTES     = 16'd512;
  localparam logic [15:0] RST_ROOT_ENTRY_COUNT = 16'd224;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_WALK = 1'b1;

  typedef struct packed {
    logic load_wr;
    logic walk_start;
    logic rd_second;
    logic advance;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic end_mark;
  } dp_stat_t;

  // byte address of the first byte read for a cluster's entry
  function automatic logic [12:0] entry_addr(input logic [11:0] clu);
    logic [12:0] half;
    begin
      half = {2'b00, clu[11:1]};
      entry_addr = half + {half[11:0], 1'b0} + {12'b0, clu[0]};
    end
  endfunction

endpackage

/* hdl/fccw_if.sv */
// Channel interfaces: request, result and configuration write.
`timescale 1ns / 1ps
interface fccw_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [12:0] table_index;
  logic [7:0]  table_byte;
  logic [11:0] start_cluster;
  modport source (output valid, req_type, table_index, table_byte, start_cluster,
                  input ready);
  modport sink (input valid, req_type, table_index, table_byte, start_cluster,
                output ready);
endinterface

interface fccw_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] cluster;
  logic [40:0] byte_offset;
  logic        last;
  logic        truncated;
  modport source (output valid, cluster, byte_offset, last, truncated, input ready);
  modport sink (input valid, cluster, byte_offset, last, truncated, output ready);
endinterface

interface fccw_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/fccw_dp.sv */
// Datapath: FAT store, cluster registers, offset arithmetic, result payload.
`timescale 1ns / 1ps
module fccw_dp import fccw_pkg::*; #(
  parameter int TABLE_BYTES = 8192
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [12:0] table_index,
  input  logic [7:0]  table_byte,
  input  logic [11:0] start_cluster,
  input  logic        cfg_wr,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic [11:0] out_cluster,
  output logic [40:0] out_byte_offset
);

  localparam int          AW    = $clog2(TABLE_BYTES);
  localparam logic [16:0] DEPTH = 17'(TABLE_BYTES);

  logic [7:0] mem [TABLE_BYTES];

  logic [15:0] reserved_r, spf_r, sb_r, root_r;
  logic [7:0]  copies_r;

  logic [11:0]        cur_r;
  logic [12:0]        addr_r;
  logic [7:0]         lo_r;
  logic [7:0]         rdata_r;
  logic               rd_oor_r;
  logic [23:0]        s0_r;
  logic signed [25:0] sec_r;
  logic [11:0]        out_cluster_r;
  logic [40:0]        out_offset_r;

  logic [16:0]        wr_ext;
  logic [16:0]        rd_ext;
  logic [12:0]        rd_addr;
  logic               rd_en;
  logic [7:0]         rd_byte;
  logic [11:0]        nxt;
  logic [23:0]        s0_calc;
  logic signed [42:0] prod;
  logic [40:0]        offset;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserved_r <= RST_RESERVED_SECTORS;
      copies_r   <= RST_FAT_COPIES;
      spf_r      <= RST_SECTORS_PER_FAT;
      sb_r       <= RST_SECTOR_BYTES;
      root_r     <= RST_ROOT_ENTRY_COUNT;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_RESERVED_SECTORS: reserved_r <= cfg_data;
        CFG_FAT_COPIES:       copies_r   <= cfg_data[7:0];
        CFG_SECTORS_PER_FAT:  spf_r      <= cfg_data;
        CFG_SECTOR_BYTES:     sb_r       <= cfg_data;
        CFG_ROOT_ENTRY_COUNT: root_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign wr_ext = {4'b0, table_index};

  always_ff @(posedge clk) begin
    if (cmd.load_wr && (wr_ext < DEPTH)) begin
      mem[wr_ext[AW-1:0]] <= table_byte;
    end
  end

  assign rd_byte = rd_oor_r ? 8'h00 : rdata_r;
  assign nxt = cur_r[0] ? {rd_byte, lo_r[7:4]} : {rd_byte[3:0] & NIBBLE, lo_r};

  always_comb begin
    if (cmd.walk_start) begin
      rd_addr = entry_addr(start_cluster);
    end else if (cmd.advance) begin
      rd_addr = entry_addr(nxt);
    end else begin
      rd_addr = addr_r + 13'd1;
    end
  end

  assign rd_en  = cmd.walk_start | cmd.advance | cmd.rd_second;
  assign rd_ext = {4'b0, rd_addr};

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r  <= mem[rd_ext[AW-1:0]];
      rd_oor_r <= !(rd_ext < DEPTH);
    end
  end

  assign s0_calc = {8'b0, reserved_r} + ({16'b0, copies_r} * {8'b0, spf_r});

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      cur_r  <= start_cluster;
      addr_r <= rd_addr;
      s0_r   <= s0_calc;
    end else if (cmd.advance) begin
      cur_r  <= nxt;
      addr_r <= rd_addr;
    end
    if (cmd.rd_second) begin
      lo_r  <= rd_byte;
      sec_r <= $signed({2'b00, s0_r}) + $signed({14'b0, cur_r}) - 26'sd2;
    end
  end

  assign prod   = sec_r * $signed({1'b0, sb_r});
  assign offset = prod[40:0] + {20'b0, root_r, {DIR_ENTRY_LOG2{1'b0}}};

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_cluster_r <= cur_r;
      out_offset_r  <= offset;
    end
  end

  assign stat.end_mark   = (nxt >= END_MARK);
  assign out_cluster     = out_cluster_r;
  assign out_byte_offset = out_offset_r;

endmodule

/* hdl/fccw_ctrl.sv */
// Controller: walk sequencing, chain count and result handshake.
`timescale 1ns / 1ps
module fccw_ctrl import fccw_pkg::*; #(
  parameter int MAX_CHAIN = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_req_type,
  output logic     out_valid,
  input  logic     out_ready,
  output logic     out_last,
  output logic     out_truncated,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD2  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       last_r, trunc_r;
  logic       out_free, at_limit, fin;

  assign out_free = !out_valid_r || out_ready;
  assign at_limit = (cnt_r == 7'(MAX_CHAIN - 1));
  assign fin      = stat.end_mark || at_limit;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_req_type == REQ_WALK) begin
            cmd.walk_start = 1'b1;
            cnt_nxt        = 7'd0;
            state_nxt      = S_RD2;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      S_RD2: begin
        cmd.rd_second = 1'b1;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          cnt_nxt  = cnt_r + 7'd1;
          if (fin) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = S_RD2;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 7'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      last_r  <= fin;
      trunc_r <= at_limit && !stat.end_mark;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_last      = last_r;
  assign out_truncated = trunc_r;

endmodule

/* hdl/fat12_cluster_chain_walker.sv */
// Top level of the FAT12 cluster chain walker.
//
//   channel  dir  payload                                         handshake
//   in_ch    in   req_type, table_index, table_byte, start_cluster valid/ready
//   out_ch   out  cluster, byte_offset, last, truncated            valid/ready
//   cfg_ch   in   index, data                                      valid/ready
//
// A load item writes one byte of the store. In a walk each cluster needs two
// reads of the single-port FAT store, one byte a cycle unless a result stalls.
// Results leave through one output register; a stalled result holds the walk.
// Reset (rst_n low, synchronous) restores register defaults; the store is
// not cleared. Configuration writes are taken in every cycle.
`timescale 1ns / 1ps
module fat12_cluster_chain_walker import fccw_pkg::*; #(
  parameter int TABLE_BYTES = 8192,
  parameter int MAX_CHAIN   = 64
) (
  input logic          clk,
  input logic          rst_n,
  fccw_in_if.sink      in_ch,
  fccw_out_if.source   out_ch,
  fccw_cfg_if.sink     cfg_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  fccw_ctrl #(
    .MAX_CHAIN (MAX_CHAIN)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_req_type   (in_ch.req_type),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_last      (out_ch.last),
    .out_truncated (out_ch.truncated),
    .cmd           (cmd),
    .stat          (stat)
  );

  fccw_dp #(
    .TABLE_BYTES (TABLE_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .table_index     (in_ch.table_index),
    .table_byte      (in_ch.table_byte),
    .start_cluster   (in_ch.start_cluster),
    .cfg_wr          (cfg_ch.valid & cfg_ch.ready),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .out_cluster     (out_ch.cluster),
    .out_byte_offset (out_ch.byte_offset)
  );

endmodule
